### hw/rtl/three_wire_rtc_serial_master_assert.svh
// Assertion macros for the three-wire serial master.
// All of them sample on clk_i and are disabled while rst_ni is low.
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_ASSERT_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_ASSERT_SVH

`ifndef SYNTHESIS
`define RTCSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RTCSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RTCSM_ASSERT(lbl, prop, msg)
`define RTCSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/rtcsm_pkg.sv
`timescale 1ns / 1ps
package rtcsm_pkg;

  localparam int BitsPerField = 8;
  localparam int ShiftWidth   = 2 * BitsPerField;
  localparam int BitIdxWidth  = 5;
  localparam int PhaseWidth   = 16;

  // request codes on the input tuser
  localparam logic [1:0] ReqRead  = 2'd1;
  localparam logic [1:0] ReqWrite = 2'd2;

  typedef enum logic [1:0] {
    KindTick,
    KindRead,
    KindWrite
  } req_kind_e;

  // classified request as it sits in the queue
  typedef struct packed {
    req_kind_e               kind;
    logic [ShiftWidth-1:0]   shift_word;  // {write data, command}, read bit already forced
    logic                    io;
  } req_t;

  typedef struct packed {
    logic                    rejected;
    logic [BitsPerField-1:0] read_data;
    logic                    done;
    logic                    busy;
    logic                    io_drive;
    logic                    io_out;
    logic                    serial_clock;
    logic                    chip_enable;
  } result_t;

endpackage

### hw/rtl/rtcsm_front.sv
`timescale 1ns / 1ps
module rtcsm_front import rtcsm_pkg::*; #(
  parameter int Depth = 2  // at least 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              in_type_i,
  input  logic [BitsPerField-1:0] in_cmd_i,
  input  logic [BitsPerField-1:0] in_wdat_i,
  input  logic                    in_io_i,
  output logic                    q_valid_o,
  output req_t                    q_req_o,
  input  logic                    q_pop_i
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  req_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  req_t             req_in;
  logic             push, pop;

  always_comb begin
    req_in.io = in_io_i;
    req_in.shift_word = {in_wdat_i, in_cmd_i};
    if (in_type_i == ReqRead) begin
      req_in.kind = KindRead;
      req_in.shift_word[0] = 1'b1;
    end else if (in_type_i == ReqWrite) begin
      req_in.kind = KindWrite;
    end else begin
      req_in.kind = KindTick;
    end
  end

  assign in_ready_o = (count_q != CntW'(Depth));
  assign q_valid_o  = (count_q != '0);
  assign q_req_o    = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_in;
    end
  end

endmodule

### hw/rtl/rtcsm_back.sv
`timescale 1ns / 1ps
module rtcsm_back import rtcsm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [PhaseWidth-1:0] cfg_data_i,
  input  logic                  q_valid_i,
  input  req_t                  q_req_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output result_t               out_res_o
);

  typedef enum logic [1:0] {
    PhClkLow,
    PhData,
    PhClkHigh,
    PhEnd
  } phase_e;

  logic [PhaseWidth-1:0]   phase_len_q;
  logic                    active_q, active_d;
  logic                    is_read_q, is_read_d;
  logic [BitIdxWidth-1:0]  bit_q, bit_d, bit_inc;
  phase_e                  phase_q, phase_d;
  logic [PhaseWidth-1:0]   tick_q, tick_d;
  logic [ShiftWidth-1:0]   out_shift_q, out_shift_d;
  logic [BitsPerField-1:0] in_shift_q, in_shift_d;
  logic                    ce_q, ce_d, clk_q, clk_d, io_q, io_d, drv_q, drv_d;
  logic                    out_valid_q;
  result_t                 res_q, res_d;

  logic                    step, start, reading, last_tick;
  logic [PhaseWidth-1:0]   len;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;
  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign step        = q_pop_o;

  assign start   = (q_req_i.kind != KindTick);
  // data bits of a read: bit index 8..15
  assign reading = is_read_q && (bit_q[BitIdxWidth-1:3] == 2'b01);
  assign len     = (phase_len_q == '0) ? PhaseWidth'(1) : phase_len_q;
  assign last_tick = ({1'b0, tick_q} + 17'd1) >= {1'b0, len};
  assign bit_inc = bit_q + 1'b1;

  always_comb begin
    active_d    = active_q;
    is_read_d   = is_read_q;
    bit_d       = bit_q;
    phase_d     = phase_q;
    tick_d      = tick_q;
    out_shift_d = out_shift_q;
    in_shift_d  = in_shift_q;
    ce_d        = ce_q;
    clk_d       = clk_q;
    io_d        = io_q;
    drv_d       = drv_q;
    res_d       = '0;

    if (start && !active_q) begin
      active_d    = 1'b1;
      is_read_d   = (q_req_i.kind == KindRead);
      out_shift_d = q_req_i.shift_word;
      in_shift_d  = '0;
      bit_d       = '0;
      phase_d     = PhClkLow;
      tick_d      = '0;
      ce_d        = 1'b1;
      clk_d       = 1'b0;
      io_d        = 1'b1;
      drv_d       = 1'b1;
    end else begin
      res_d.rejected = start;  // only reached here with a start when busy
      if (active_q) begin
        if (phase_q == PhEnd) begin
          ce_d       = 1'b0;
          drv_d      = 1'b1;
          active_d   = 1'b0;
          res_d.done = 1'b1;
          phase_d    = PhClkLow;
          tick_d     = '0;
          bit_d      = '0;
          if (is_read_q) begin
            res_d.read_data = in_shift_q;
          end
        end else begin
          if (tick_q == '0) begin
            case (phase_q)
              PhClkLow: begin
                clk_d = 1'b0;
                if (reading) begin
                  drv_d = 1'b0;
                end
              end
              PhData: begin
                if (reading) begin
                  if (q_req_i.io) begin
                    in_shift_d[bit_q[2:0]] = 1'b1;
                  end
                end else begin
                  io_d = out_shift_q[bit_q[3:0]];
                end
              end
              default: clk_d = 1'b1;
            endcase
          end
          if (last_tick) begin
            tick_d = '0;
            if (phase_q == PhClkHigh) begin
              bit_d   = bit_inc;
              phase_d = bit_inc[BitIdxWidth-1] ? PhEnd : PhClkLow;
            end else begin
              phase_d = phase_e'(phase_q + 2'd1);
            end
          end else begin
            tick_d = tick_q + 1'b1;
          end
        end
      end
    end

    res_d.chip_enable  = ce_d;
    res_d.serial_clock = clk_d;
    res_d.io_out       = io_d;
    res_d.io_drive     = drv_d;
    res_d.busy         = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_len_q <= PhaseWidth'(1);
      active_q    <= 1'b0;
      is_read_q   <= 1'b0;
      bit_q       <= '0;
      phase_q     <= PhClkLow;
      tick_q      <= '0;
      out_shift_q <= '0;
      in_shift_q  <= '0;
      ce_q        <= 1'b0;
      clk_q       <= 1'b0;
      io_q        <= 1'b0;
      drv_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        phase_len_q <= cfg_data_i;
      end
      if (step) begin
        active_q    <= active_d;
        is_read_q   <= is_read_d;
        bit_q       <= bit_d;
        phase_q     <= phase_d;
        tick_q      <= tick_d;
        out_shift_q <= out_shift_d;
        in_shift_q  <= in_shift_d;
        ce_q        <= ce_d;
        clk_q       <= clk_d;
        io_q        <= io_d;
        drv_q       <= drv_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

endmodule

### hw/rtl/three_wire_rtc_serial_master.sv
`timescale 1ns / 1ps
// A tick's result reaches m_axis through the request queue, then the output register.
// Throughput: one tick per cycle unless m_axis stalls; pin state updates once per popped tick.
// Backpressure on m_axis fills the request queue (QUEUE_DEPTH entries) before s_axis stalls.
// Reset (rst_ni low, async): idle, chip enable low, clock low, data driven, phase length 1.
module three_wire_rtc_serial_master import rtcsm_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [PhaseWidth-1:0] cfg_data_i,     // phase_length
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [23:0]           s_axis_tdata_i, // cmd_address, write_data, io_in, zero pad
  input  logic [1:0]            s_axis_tuser_i, // req_type
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [15:0]           m_axis_tdata_o  // chip_enable, serial_clock, io_out, io_drive,
                                                // busy_res, done_res, read_data, rejected, pad
);

  `include "three_wire_rtc_serial_master_assert.svh"

  logic    q_valid, q_pop;
  req_t    q_req;
  result_t res;
  logic    out_done, out_busy, out_rej;

  assign cfg_ready_o = 1'b1;

  rtcsm_front #(
    .Depth (QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_type_i  (s_axis_tuser_i),
    .in_cmd_i   (s_axis_tdata_i[7:0]),
    .in_wdat_i  (s_axis_tdata_i[15:8]),
    .in_io_i    (s_axis_tdata_i[16]),
    .q_valid_o  (q_valid),
    .q_req_o    (q_req),
    .q_pop_i    (q_pop)
  );

  rtcsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_req_i     (q_req),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o = {1'b0, res};

  assign out_done = m_axis_tvalid_o && res.done;
  assign out_busy = m_axis_tvalid_o && res.busy;
  assign out_rej  = m_axis_tvalid_o && res.rejected;

  // a start on the ending tick is rejected while the transfer reports done
  `RTCSM_ASSERT(a_done_idle, out_done |-> (!res.chip_enable && !res.busy), "done while still busy")
  `RTCSM_ASSERT(a_busy_ce, out_busy |-> res.chip_enable, "busy without chip enable")
  `RTCSM_ASSERT(a_reject_busy, out_rej |-> (res.busy || res.done), "reject reported while idle")
  `RTCSM_ASSERT_NEXT(a_queue_fill, (s_axis_tvalid_i && s_axis_tready_o), q_valid, "queue empty")

endmodule
